### rtl/sfc_pkg.sv
// Shared constants, codes and plane tables for the sphere frustum culler.
package sfc_pkg;

   localparam int NUM_PLANES       = 6;
   localparam int NUM_AXES         = 3;
   localparam int MATRIX_ROWS      = 4;
   localparam int MATRIX_HALF_BITS = 16;
   localparam int COORD_FRAC       = 8;
   localparam int PLANE_BITS       = 3;
   localparam int AXIS_BITS        = 2;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 64;
   localparam int VERDICT_BITS     = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MATRIX_COL0 = 3'd0,
      CSR_MATRIX_COL1 = 3'd1,
      CSR_MATRIX_COL2 = 3'd2,
      CSR_MATRIX_COL3 = 3'd3,
      CSR_NORMALIZE   = 3'd4
   } csr_index_type;

   typedef enum logic [VERDICT_BITS-1:0] {
      VERDICT_INSIDE    = 2'd0,
      VERDICT_INTERSECT = 2'd1,
      VERDICT_OUTSIDE   = 2'd2
   } verdict_type;

   // Matrix column paired with column 3: left, right, top, bottom, near, far.
   function automatic logic [AXIS_BITS-1:0] plane_axis(input logic [PLANE_BITS-1:0] plane);
      logic [AXIS_BITS-1:0] axis;
      case (plane)
         3'd0, 3'd1: axis = 2'd0;
         3'd2, 3'd3: axis = 2'd1;
         default:    axis = 2'd2;
      endcase
      return axis;
   endfunction

   // True where the plane adds the paired column, false where it subtracts it.
   function automatic logic plane_adds(input logic [PLANE_BITS-1:0] plane);
      logic adds;
      case (plane)
         3'd0, 3'd3, 3'd4: adds = 1'b1;
         default:          adds = 1'b0;
      endcase
      return adds;
   endfunction

endpackage

### rtl/sfc_mul.sv
// Two-stage unsigned multiplier built from four half-width partial products.
module sfc_mul #(
   parameter int A_BITS = 32,
   parameter int B_BITS = 32
) (
   input  logic                       clock,
   input  logic [A_BITS-1:0]          a,
   input  logic [B_BITS-1:0]          b,
   output logic [A_BITS+B_BITS-1:0]   p
);

   localparam int HALF = ((A_BITS > B_BITS ? A_BITS : B_BITS) + 1) / 2;
   localparam int PPW  = 2 * HALF;
   localparam int SUMW = 4 * HALF;

   logic [PPW-1:0]  a_ext;
   logic [PPW-1:0]  b_ext;
   logic [PPW-1:0]  pp_ll_in, pp_lh_in, pp_hl_in, pp_hh_in;
   logic [PPW-1:0]  pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [SUMW-1:0] sum_in;
   logic [A_BITS+B_BITS-1:0] p_ff;

   assign a_ext = PPW'(a);
   assign b_ext = PPW'(b);

   always_comb begin
      pp_ll_in = PPW'(a_ext[HALF-1:0])   * PPW'(b_ext[HALF-1:0]);
      pp_lh_in = PPW'(a_ext[HALF-1:0])   * PPW'(b_ext[PPW-1:HALF]);
      pp_hl_in = PPW'(a_ext[PPW-1:HALF]) * PPW'(b_ext[HALF-1:0]);
      pp_hh_in = PPW'(a_ext[PPW-1:HALF]) * PPW'(b_ext[PPW-1:HALF]);
   end

   always_comb begin
      sum_in = SUMW'(pp_ll_ff) + (SUMW'(pp_lh_ff) << HALF) + (SUMW'(pp_hl_ff) << HALF)
             + (SUMW'(pp_hh_ff) << PPW);
   end

   always_ff @(posedge clock) begin
      pp_ll_ff <= pp_ll_in;
      pp_lh_ff <= pp_lh_in;
      pp_hl_ff <= pp_hl_in;
      pp_hh_ff <= pp_hh_in;
      p_ff     <= sum_in[A_BITS+B_BITS-1:0];
   end

   assign p = p_ff;

endmodule

### rtl/sfc_cfg.sv
// Register bank for the matrix and mode, with registered plane normals and lengths.
module sfc_cfg #(
   parameter int MATRIX_ENTRY_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [sfc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [sfc_pkg::CSR_DATA_BITS-1:0]      csr_data,
   output logic signed [MATRIX_ENTRY_BITS:0]      plane_n [sfc_pkg::NUM_PLANES][sfc_pkg::MATRIX_ROWS],
   output logic [2*MATRIX_ENTRY_BITS+1:0]         plane_l2 [sfc_pkg::NUM_PLANES],
   output logic                                   normalize
);

   localparam int MB   = MATRIX_ENTRY_BITS;
   localparam int NW   = MB + 1;
   localparam int SQW  = 2 * MB + 1;
   localparam int SQFW = 2 * NW;
   localparam int LW   = 2 * MB + 2;

   logic signed [MB-1:0]  entry_ff [sfc_pkg::MATRIX_ROWS][sfc_pkg::MATRIX_ROWS];
   logic                  normalize_ff;
   logic                  write_en;
   logic signed [NW-1:0]  n_in  [sfc_pkg::NUM_PLANES][sfc_pkg::MATRIX_ROWS];
   logic signed [NW-1:0]  n_ff  [sfc_pkg::NUM_PLANES][sfc_pkg::MATRIX_ROWS];
   logic [SQW-1:0]        sq_in [sfc_pkg::NUM_PLANES][sfc_pkg::NUM_AXES];
   logic [SQW-1:0]        sq_ff [sfc_pkg::NUM_PLANES][sfc_pkg::NUM_AXES];
   logic [LW-1:0]         l2_in [sfc_pkg::NUM_PLANES];
   logic [LW-1:0]         l2_ff [sfc_pkg::NUM_PLANES];

   assign write_en = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int col = 0; col < sfc_pkg::MATRIX_ROWS; col++) begin
            for (int row = 0; row < sfc_pkg::MATRIX_ROWS; row++) begin
               entry_ff[col][row] <= '0;
            end
         end
         normalize_ff <= 1'b0;
      end else if (write_en) begin
         case (csr_index)
            sfc_pkg::CSR_MATRIX_COL0: begin
               for (int row = 0; row < sfc_pkg::MATRIX_ROWS; row++)
                  entry_ff[0][row] <= csr_data[row*sfc_pkg::MATRIX_HALF_BITS +: MB];
            end
            sfc_pkg::CSR_MATRIX_COL1: begin
               for (int row = 0; row < sfc_pkg::MATRIX_ROWS; row++)
                  entry_ff[1][row] <= csr_data[row*sfc_pkg::MATRIX_HALF_BITS +: MB];
            end
            sfc_pkg::CSR_MATRIX_COL2: begin
               for (int row = 0; row < sfc_pkg::MATRIX_ROWS; row++)
                  entry_ff[2][row] <= csr_data[row*sfc_pkg::MATRIX_HALF_BITS +: MB];
            end
            sfc_pkg::CSR_MATRIX_COL3: begin
               for (int row = 0; row < sfc_pkg::MATRIX_ROWS; row++)
                  entry_ff[3][row] <= csr_data[row*sfc_pkg::MATRIX_HALF_BITS +: MB];
            end
            sfc_pkg::CSR_NORMALIZE: begin
               normalize_ff <= csr_data[0];
            end
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   // Plane component = column 3 plus or minus the paired column, row by row.
   always_comb begin
      logic signed [NW-1:0] base;
      logic signed [NW-1:0] pair;
      for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
         for (int row = 0; row < sfc_pkg::MATRIX_ROWS; row++) begin
            base = NW'(entry_ff[3][row]);
            pair = NW'(entry_ff[sfc_pkg::plane_axis(sfc_pkg::PLANE_BITS'(p))][row]);
            n_in[p][row] = sfc_pkg::plane_adds(sfc_pkg::PLANE_BITS'(p)) ? base + pair
                                                                         : base - pair;
         end
      end
   end

   always_comb begin
      logic signed [SQFW-1:0] sq_full;
      for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
         for (int k = 0; k < sfc_pkg::NUM_AXES; k++) begin
            sq_full     = SQFW'(n_ff[p][k]) * SQFW'(n_ff[p][k]);
            sq_in[p][k] = sq_full[SQW-1:0];
         end
         l2_in[p] = LW'(sq_ff[p][0]) + LW'(sq_ff[p][1]) + LW'(sq_ff[p][2]);
      end
   end

   always_ff @(posedge clock) begin
      n_ff  <= n_in;
      sq_ff <= sq_in;
      l2_ff <= l2_in;
   end

   assign plane_n   = n_ff;
   assign plane_l2  = l2_ff;
   assign normalize = normalize_ff;

endmodule

### rtl/sphere_frustum_cull.sv
// Top level of the sphere frustum culler: eight-stage classification pipeline.
//
//   channel   dir   handshake                       beat payload
//   request   in    start high, busy low            req_center_x/y/z, req_radius
//   response  out   rsp_valid for one cycle         rsp_verdict
//   csr       in    csr_valid and csr_ready high    csr_index, csr_data
//
// One request beat enters per clock while busy is low. Its verdict passes
// through the capture, product, distance, magnitude, two multiplier, decision
// and verdict registers. Two paths set the depth, and both end at stage 6. One
// is the plane distance, its magnitude and a split multiplier that squares it.
// The other is r + 2 through two chained split multipliers that form
// (r + 2)^2 * |n|^2.
// Reset is synchronous: it clears the matrix, the mode bit and the valid chain,
// and holds busy high (and csr_ready low) until the cycle after it drops.
// A csr write moves through the normal, square and length registers in turn;
// beats are not held back meanwhile. The receiver cannot stall the pipeline.
module sphere_frustum_cull #(
   parameter int MATRIX_ENTRY_BITS = 16,
   parameter int COORD_BITS        = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [COORD_BITS-1:0]           req_center_x,
   input  logic signed [COORD_BITS-1:0]           req_center_y,
   input  logic signed [COORD_BITS-1:0]           req_center_z,
   input  logic [COORD_BITS-1:0]                  req_radius,
   output logic                                   rsp_valid,
   output logic [sfc_pkg::VERDICT_BITS-1:0]       rsp_verdict,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sfc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [sfc_pkg::CSR_DATA_BITS-1:0]      csr_data
);

   localparam int MB    = MATRIX_ENTRY_BITS;
   localparam int CB    = COORD_BITS;
   localparam int NW    = MB + 1;          // plane component
   localparam int FRAC  = MB - 4;          // fraction bits of a matrix entry
   localparam int PW    = NW + CB;         // component times coordinate
   localparam int DW    = PW + 2;          // plane distance d
   localparam int TW    = DW + 1;          // d + 2 against +/- r
   localparam int LW    = 2 * MB + 2;      // |n|^2
   localparam int BSW   = CB + 1;          // r + 2
   localparam int BQW   = 2 * BSW;
   localparam int EQW   = 2 * CB;
   localparam int BLW   = BQW + LW;
   localparam int ELW   = EQW + LW;
   localparam int CW    = 2 * DW;          // squared compares
   localparam int DEPTH = 8;

   localparam logic [CB-1:0]        TWO_COORD = CB'(2) << sfc_pkg::COORD_FRAC;
   localparam logic signed [TW-1:0] TWO_PLANE = TW'(1) << (FRAC + sfc_pkg::COORD_FRAC + 1);

   // Plane data from the register bank
   logic signed [NW-1:0] plane_n [sfc_pkg::NUM_PLANES][sfc_pkg::MATRIX_ROWS];
   logic [LW-1:0]        plane_l2 [sfc_pkg::NUM_PLANES];
   logic                 normalize;

   logic                 busy_ff;
   logic                 accept;
   logic [DEPTH:1]       valid_ff;

   // Stage 1: captured beat
   logic signed [CB-1:0] c1_ff [sfc_pkg::NUM_AXES];
   logic [CB-1:0]        r1_ff;

   // Stage 2: products and radius terms
   logic signed [PW-1:0] prod_in [sfc_pkg::NUM_PLANES][sfc_pkg::NUM_AXES];
   logic signed [PW-1:0] prod_ff [sfc_pkg::NUM_PLANES][sfc_pkg::NUM_AXES];
   logic [BSW-1:0]       bsum_in, bsum_ff;
   logic [CB-1:0]        eabs_in, eabs_ff;
   logic                 eneg_in, eneg2_ff;
   logic [CB-1:0]        r2_ff;

   // Stage 3: plane distance
   logic signed [DW-1:0] d_in [sfc_pkg::NUM_PLANES];
   logic signed [DW-1:0] d3_ff [sfc_pkg::NUM_PLANES];
   logic [CB-1:0]        r3_ff;
   logic                 eneg3_ff;

   // Stage 4: magnitude, sign and the plain test
   logic [DW-1:0]        dabs_in [sfc_pkg::NUM_PLANES];
   logic [DW-1:0]        dabs4_ff [sfc_pkg::NUM_PLANES];
   logic [sfc_pkg::NUM_PLANES-1:0] dneg_in, nn_out_in, nn_int_in;
   logic [sfc_pkg::NUM_PLANES-1:0] dneg4_ff, nn_out4_ff, nn_int4_ff;
   logic                 eneg4_ff;
   logic [BQW-1:0]       bsq4;
   logic [EQW-1:0]       esq4;

   // Stages 5 and 6: hold flags while the squares finish
   logic [sfc_pkg::NUM_PLANES-1:0] dneg5_ff, nn_out5_ff, nn_int5_ff;
   logic [sfc_pkg::NUM_PLANES-1:0] dneg6_ff, nn_out6_ff, nn_int6_ff;
   logic                 eneg5_ff, eneg6_ff;
   logic [CW-1:0]        d2_6 [sfc_pkg::NUM_PLANES];
   logic [BLW-1:0]       bl6  [sfc_pkg::NUM_PLANES];
   logic [ELW-1:0]       el6  [sfc_pkg::NUM_PLANES];

   // Stage 7: per-plane decision; stage 8: first decisive plane
   logic [sfc_pkg::NUM_PLANES-1:0] out_in, int_in, out7_ff, int7_ff;
   sfc_pkg::verdict_type verdict_in, verdict_ff;

   sfc_cfg #(
      .MATRIX_ENTRY_BITS (MB)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .plane_n   (plane_n),
      .plane_l2  (plane_l2),
      .normalize (normalize)
   );

   // Hold busy through reset and into the cycle after it drops
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy      = busy_ff;
   assign csr_ready = ~busy_ff;
   assign accept    = start & ~busy_ff;

   // Valid bits advance with the data, one stage a clock
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[DEPTH-1:1], accept};
      end
   end

   // Stage 2 logic: component products, r + 2 and |r - 2|
   always_comb begin
      for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
         for (int k = 0; k < sfc_pkg::NUM_AXES; k++) begin
            prod_in[p][k] = PW'(plane_n[p][k]) * PW'(c1_ff[k]);
         end
      end
      bsum_in = BSW'(r1_ff) + BSW'(TWO_COORD);
      eneg_in = r1_ff < TWO_COORD;
      eabs_in = eneg_in ? TWO_COORD - r1_ff : r1_ff - TWO_COORD;
   end

   // Stage 3 logic: d = n.c + w, with w at the centre's scale
   always_comb begin
      for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
         d_in[p] = DW'(prod_ff[p][0]) + DW'(prod_ff[p][1]) + DW'(prod_ff[p][2])
                 + (DW'(plane_n[p][3]) <<< sfc_pkg::COORD_FRAC);
      end
   end

   // Stage 4 logic: plain test d + 2 against -r and +r, and |d| for squaring
   always_comb begin
      logic signed [TW-1:0] t_val;
      logic signed [TW-1:0] r_scaled;
      r_scaled = $signed(TW'(r3_ff)) <<< FRAC;
      for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
         t_val        = TW'(d3_ff[p]) + TWO_PLANE;
         nn_out_in[p] = t_val < -r_scaled;
         nn_int_in[p] = t_val < r_scaled;
         dneg_in[p]   = d3_ff[p][DW-1];
         dabs_in[p]   = dneg_in[p] ? $unsigned(-d3_ff[p]) : $unsigned(d3_ff[p]);
      end
   end

   always_ff @(posedge clock) begin
      c1_ff[0]   <= req_center_x;
      c1_ff[1]   <= req_center_y;
      c1_ff[2]   <= req_center_z;
      r1_ff      <= req_radius;

      prod_ff    <= prod_in;
      bsum_ff    <= bsum_in;
      eabs_ff    <= eabs_in;
      eneg2_ff   <= eneg_in;
      r2_ff      <= r1_ff;

      d3_ff      <= d_in;
      r3_ff      <= r2_ff;
      eneg3_ff   <= eneg2_ff;

      dabs4_ff   <= dabs_in;
      dneg4_ff   <= dneg_in;
      nn_out4_ff <= nn_out_in;
      nn_int4_ff <= nn_int_in;
      eneg4_ff   <= eneg3_ff;

      dneg5_ff   <= dneg4_ff;
      nn_out5_ff <= nn_out4_ff;
      nn_int5_ff <= nn_int4_ff;
      eneg5_ff   <= eneg4_ff;

      dneg6_ff   <= dneg5_ff;
      nn_out6_ff <= nn_out5_ff;
      nn_int6_ff <= nn_int5_ff;
      eneg6_ff   <= eneg5_ff;

      out7_ff    <= out_in;
      int7_ff    <= int_in;

      verdict_ff <= verdict_in;
   end

   // Radius squares: stage 2 in, stage 4 out
   sfc_mul #(.A_BITS(BSW), .B_BITS(BSW)) u_bsq (
      .clock (clock), .a (bsum_ff), .b (bsum_ff), .p (bsq4)
   );

   sfc_mul #(.A_BITS(CB), .B_BITS(CB)) u_esq (
      .clock (clock), .a (eabs_ff), .b (eabs_ff), .p (esq4)
   );

   // Per plane: d^2 and the radius squares scaled by |n|^2, stage 4 in, stage 6 out
   for (genvar gp = 0; gp < sfc_pkg::NUM_PLANES; gp++) begin : g_plane
      sfc_mul #(.A_BITS(DW), .B_BITS(DW)) u_dsq (
         .clock (clock), .a (dabs4_ff[gp]), .b (dabs4_ff[gp]), .p (d2_6[gp])
      );

      sfc_mul #(.A_BITS(BQW), .B_BITS(LW)) u_bl (
         .clock (clock), .a (bsq4), .b (plane_l2[gp]), .p (bl6[gp])
      );

      sfc_mul #(.A_BITS(EQW), .B_BITS(LW)) u_el (
         .clock (clock), .a (esq4), .b (plane_l2[gp]), .p (el6[gp])
      );
   end

   // Stage 7 logic. Normalised: out when d < -(r+2)L, intersecting when
   // d < (r-2)L; both sides squared with their signs kept. Else the plain test.
   always_comb begin
      logic out_norm;
      logic int_norm;
      for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
         out_norm = dneg6_ff[p] & (d2_6[p] > CW'(bl6[p]));
         if (eneg6_ff) begin
            int_norm = dneg6_ff[p] & (d2_6[p] > CW'(el6[p]));
         end else begin
            int_norm = dneg6_ff[p] | (d2_6[p] < CW'(el6[p]));
         end
         out_in[p] = normalize ? out_norm : nn_out6_ff[p];
         int_in[p] = normalize ? int_norm : nn_int6_ff[p];
      end
   end

   // Stage 8 logic: the lowest decisive plane sets the verdict
   always_comb begin
      verdict_in = sfc_pkg::VERDICT_INSIDE;
      for (int p = sfc_pkg::NUM_PLANES - 1; p >= 0; p--) begin
         if (out7_ff[p]) begin
            verdict_in = sfc_pkg::VERDICT_OUTSIDE;
         end else if (int7_ff[p]) begin
            verdict_in = sfc_pkg::VERDICT_INTERSECT;
         end
      end
   end

   assign rsp_valid   = valid_ff[DEPTH];
   assign rsp_verdict = verdict_ff;

endmodule

### tb/sv/tb_top.sv
// Self-checking bench for the sphere frustum culler: directed planes, extremes, random spheres.
module tb_top;
   import sfc_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 12;
   localparam int COORD_W        = 24;
   localparam int MAT_FRAC       = 12;
   localparam int PIPE_LATENCY   = 8;
   localparam int IDLE_PCT       = 32;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RAND_PHASES    = 10;
   localparam int SPHERES_PER_PHASE = 85;
   localparam int QUIET_PHASE    = 4;

   // Constant 2 at the plane-distance scale, and 2.0 in the centre format.
   localparam longint      TWO_SCALED = 64'sd1 <<< (MAT_FRAC + COORD_FRAC + 1);
   localparam logic [63:0] TWO_COORD  = 64'd2 << COORD_FRAC;

   localparam logic [15:0] ONE_Q12     = 16'h1000;
   localparam logic [15:0] MINUS_ONE_Q12 = 16'hF000;
   localparam logic signed [COORD_W-1:0] COORD_MAX  = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN  = 24'sh800000;
   localparam logic [COORD_W-1:0]        RADIUS_MAX = 24'hFFFFFF;

   typedef enum int {
      PLANE_LEFT, PLANE_RIGHT, PLANE_TOP, PLANE_BOTTOM, PLANE_NEAR, PLANE_FAR
   } frustum_plane_e;

   logic                       clock        = 1'b0;
   logic                       reset        = 1'b1;
   logic                       start        = 1'b0;
   logic                       busy;
   logic signed [COORD_W-1:0]  req_center_x = '0;
   logic signed [COORD_W-1:0]  req_center_y = '0;
   logic signed [COORD_W-1:0]  req_center_z = '0;
   logic [COORD_W-1:0]         req_radius   = '0;
   logic                       rsp_valid;
   logic [VERDICT_BITS-1:0]    rsp_verdict;
   logic                       csr_valid    = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index    = '0;
   logic [CSR_DATA_BITS-1:0]   csr_data     = '0;

   // Mirror of the culler's registers, updated as each csr beat is taken.
   logic [63:0] mat_col [4] = '{default: 64'd0};
   logic        norm_on     = 1'b0;

   verdict_type expected_verdicts [$];
   verdict_type oldest_verdict;
   bit          gaps_on         = 1'b1;
   int          error_count     = 0;
   int          spheres_sent    = 0;
   int          csr_beats       = 0;
   int          settings_loaded = 0;
   int          inside_seen     = 0;
   int          intersect_seen  = 0;
   int          outside_seen    = 0;
   int          quiet_cycles    = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   sphere_frustum_cull #(
      .MATRIX_ENTRY_BITS(16),
      .COORD_BITS       (COORD_W)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_center_x(req_center_x),
      .req_center_y(req_center_y),
      .req_center_z(req_center_z),
      .req_radius  (req_radius),
      .rsp_valid   (rsp_valid),
      .rsp_verdict (rsp_verdict),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // Classify one sphere against the mirrored frustum. Planes are walked in
   // order and the first decisive one sets the verdict; exact integer maths,
   // with squared compares (signs kept) in place of a root when normalising.
   function automatic verdict_type predict_verdict(input logic signed [COORD_W-1:0] cx, cy, cz,
                                                   input logic [COORD_W-1:0] rad);
      longint       cen [3];
      longint       nrm [4];
      longint       col_e, axis_e, plane_dist, shifted, r_scaled, len_sq_i;
      logic [127:0] dist_sq, outer_sq, inner_sq, len_sq;
      logic [63:0]  dist_mag, outer_b, inner_b;
      logic         inner_neg, hit, adds;
      int           axis;
      verdict_type  result;
      cen[0]   = cx;
      cen[1]   = cy;
      cen[2]   = cz;
      r_scaled = longint'({40'd0, rad}) <<< MAT_FRAC;
      result   = VERDICT_INSIDE;
      for (int p = 0; p < NUM_PLANES; p++) begin
         case (p)
            PLANE_LEFT, PLANE_RIGHT:  axis = 0;
            PLANE_TOP, PLANE_BOTTOM:  axis = 1;
            default:                  axis = 2;
         endcase
         adds = (p == PLANE_LEFT) || (p == PLANE_BOTTOM) || (p == PLANE_NEAR);
         // Plane row k: column 3 plus or minus the paired column.
         for (int k = 0; k < MATRIX_ROWS; k++) begin
            col_e  = longint'($signed(mat_col[3][16*k +: 16]));
            axis_e = longint'($signed(mat_col[axis][16*k +: 16]));
            nrm[k] = adds ? col_e + axis_e : col_e - axis_e;
         end
         plane_dist = nrm[0] * cen[0] + nrm[1] * cen[1] + nrm[2] * cen[2]
                    + (nrm[3] <<< COORD_FRAC);
         if (!norm_on) begin
            shifted = plane_dist + TWO_SCALED;
            if (shifted < -r_scaled) begin
               result = VERDICT_OUTSIDE;
               break;
            end
            if (shifted < r_scaled) begin
               result = VERDICT_INTERSECT;
               break;
            end
         end else begin
            len_sq_i  = nrm[0] * nrm[0] + nrm[1] * nrm[1] + nrm[2] * nrm[2];
            len_sq    = {64'd0, len_sq_i};
            dist_mag  = (plane_dist < 0) ? -plane_dist : plane_dist;
            dist_sq   = {64'd0, dist_mag} * {64'd0, dist_mag};
            outer_b   = {40'd0, rad} + TWO_COORD;
            outer_sq  = {64'd0, outer_b} * {64'd0, outer_b} * len_sq;
            inner_neg = rad < TWO_COORD;
            inner_b   = inner_neg ? TWO_COORD - rad : {40'd0, rad} - TWO_COORD;
            inner_sq  = {64'd0, inner_b} * {64'd0, inner_b} * len_sq;
            // d < -(r+2)L, then d < (r-2)L with the sign of (r-2) in mind.
            if (plane_dist < 0 && dist_sq > outer_sq) begin
               result = VERDICT_OUTSIDE;
               break;
            end
            if (inner_neg) hit = (plane_dist < 0) && (dist_sq > inner_sq);
            else           hit = (plane_dist < 0) || (dist_sq < inner_sq);
            if (hit) begin
               result = VERDICT_INTERSECT;
               break;
            end
         end
      end
      return result;
   endfunction

   // Offer one sphere beat, idling at random first; hold it until taken.
   // Start is left high on exit so back-to-back beats never glitch it.
   task automatic send_sphere(input logic signed [COORD_W-1:0] cx, cy, cz,
                              input logic [COORD_W-1:0] rad);
      while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_center_x <= cx;
      req_center_y <= cy;
      req_center_z <= cz;
      req_radius   <= rad;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_verdicts.push_back(predict_verdict(cx, cy, cz, rad));
      spheres_sent++;
   endtask

   // Offer one csr beat; csr_valid stays high for a following write.
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx, input logic [63:0] data);
      while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         csr_valid <= 1'b0;
         @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx < CSR_NORMALIZE)       mat_col[idx[1:0]] = data;
      else if (idx == CSR_NORMALIZE) norm_on           = data[0];
      csr_beats++;
   endtask

   // Drop start and wait for every outstanding verdict; always advance once.
   task automatic settle_pipeline();
      start <= 1'b0;
      do @(posedge clock); while (expected_verdicts.size() != 0);
   endtask

   // Load a whole frustum setting while the culler is idle.
   task automatic load_frustum(input logic [63:0] c0, c1, c2, c3, input logic [63:0] norm_word);
      settle_pipeline();
      write_csr(CSR_MATRIX_COL0, c0);
      write_csr(CSR_MATRIX_COL1, c1);
      write_csr(CSR_MATRIX_COL2, c2);
      write_csr(CSR_MATRIX_COL3, c3);
      write_csr(CSR_NORMALIZE, norm_word);
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   // Zero matrix out of reset: every plane has a zero normal and w = 0, so
   // the radius alone decides; writes to indices past the list must not land.
   task automatic test_reset_state();
      send_sphere(0, 0, 0, 0);
      send_sphere(0, 0, 0, 769);
      send_sphere(COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX);
      send_sphere(COORD_MIN, COORD_MIN, COORD_MIN, 0);
      settle_pipeline();
      for (int idx = CSR_NORMALIZE + 1; idx < (1 << CSR_INDEX_BITS); idx++)
         write_csr(CSR_INDEX_BITS'(idx), {$urandom, $urandom});
      csr_valid <= 1'b0;
      send_sphere(0, 0, 0, 769);
      send_sphere(0, 0, 0, 768);
   endtask

   // Identity matrix: a unit cube. Push a sphere out through each plane in
   // turn, probe the radius boundary, then repeat a few with normalising on.
   task automatic test_unit_frustum();
      load_frustum({48'd0, ONE_Q12}, {32'd0, ONE_Q12, 16'd0}, {16'd0, ONE_Q12, 32'd0},
                   {ONE_Q12, 48'd0}, 64'd0);
      send_sphere(0, 0, 0, 0);
      send_sphere(0, 0, 0, 768);
      send_sphere(0, 0, 0, 769);
      send_sphere(-2000, 0, 0, 0);
      send_sphere(2000, 0, 0, 0);
      send_sphere(0, 2000, 0, 0);
      send_sphere(0, -2000, 0, 0);
      send_sphere(0, 0, -2000, 0);
      send_sphere(0, 0, 2000, 0);
      load_frustum({48'd0, ONE_Q12}, {32'd0, ONE_Q12, 16'd0}, {16'd0, ONE_Q12, 32'd0},
                   {ONE_Q12, 48'd0}, 64'd1);
      send_sphere(0, 0, 0, 0);
      send_sphere(0, 0, 0, 1000);
      // Radius below 2, then at 2: the (r-2) bound turns negative, then zero.
      send_sphere(-700, 0, 0, 100);
      send_sphere(-800, 0, 0, 512);
      send_sphere(0, 0, 2000, 0);
   endtask

   // Saturated entries, zero normals while normalising, and stray mode bits.
   task automatic test_matrix_extremes();
      load_frustum({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}},
                   64'hFFFF_FFFF_FFFF_FFFE);
      send_sphere(COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX);
      send_sphere(COORD_MIN, COORD_MIN, COORD_MIN, 0);
      load_frustum({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}},
                   64'hFFFF_FFFF_FFFF_FFFF);
      send_sphere(COORD_MAX, COORD_MIN, COORD_MAX, 0);
      send_sphere(COORD_MIN, COORD_MAX, COORD_MIN, RADIUS_MAX);
      // Zero normal, negative w: out regardless of radius.
      load_frustum(64'd0, 64'd0, 64'd0, {MINUS_ONE_Q12, 48'd0}, 64'd1);
      send_sphere(0, 0, 0, 0);
      send_sphere(COORD_MAX, COORD_MIN, 0, RADIUS_MAX);
      // Zero normal, zero w: no plane decides.
      load_frustum(64'd0, 64'd0, 64'd0, 64'd0, 64'h8000_0000_0000_0001);
      send_sphere(0, 0, 0, RADIUS_MAX);
   endtask

   // Random frusta, mostly near a scaled identity so all three verdicts turn
   // up, with some fully random matrices; one phase runs with no gaps.
   task automatic test_random_spheres();
      logic [63:0]               cols [4];
      logic [63:0]               norm_word;
      logic signed [COORD_W-1:0] cx, cy, cz;
      logic [COORD_W-1:0]        rad;
      bit                        full_style;
      int                        spread;
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         full_style = ($urandom_range(99) < 30);
         for (int c = 0; c < MATRIX_ROWS; c++) begin
            for (int r = 0; r < MATRIX_ROWS; r++) begin
               if (full_style) spread = $urandom;
               else if (c == r) begin
                  spread = $urandom_range(12288, 1024);
                  if ($urandom_range(99) < 20) spread = -spread;
               end else spread = $urandom_range(1023) - 512;
               cols[c][16*r +: 16] = 16'(spread);
            end
         end
         norm_word    = {$urandom, $urandom};
         norm_word[0] = 1'(phase % 2);
         gaps_on      = (phase != QUIET_PHASE);
         load_frustum(cols[0], cols[1], cols[2], cols[3], norm_word);
         for (int i = 0; i < SPHERES_PER_PHASE; i++) begin
            if ($urandom_range(99) < 20) begin
               cx  = COORD_W'($urandom);
               cy  = COORD_W'($urandom);
               cz  = COORD_W'($urandom);
               rad = COORD_W'($urandom);
            end else begin
               cx = COORD_W'($urandom_range(2047) - 1024);
               cy = COORD_W'($urandom_range(2047) - 1024);
               cz = COORD_W'($urandom_range(2047) - 1024);
               case ($urandom_range(3))
                  0:       rad = COORD_W'($urandom_range(1023));
                  1:       rad = COORD_W'($urandom_range(4095));
                  2:       rad = COORD_W'(TWO_COORD);
                  default: rad = COORD_W'($urandom);
               endcase
            end
            send_sphere(cx, cy, cz, rad);
         end
      end
      gaps_on = 1'b1;
   endtask

   // Check each verdict beat against the oldest pending prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_verdicts.size() == 0) begin
            error_count++;
            $display("%0t: verdict with no sphere pending, expected none, actual %0d",
                     $time, rsp_verdict);
         end else begin
            oldest_verdict = expected_verdicts.pop_front();
            if (rsp_verdict !== oldest_verdict) begin
               error_count++;
               $display("%0t: verdict mismatch, expected %0d, actual %0d",
                        $time, oldest_verdict, rsp_verdict);
            end
            case (oldest_verdict)
               VERDICT_INSIDE:    inside_seen++;
               VERDICT_INTERSECT: intersect_seen++;
               default:           outside_seen++;
            endcase
         end
      end
   end

   // Abort if no beat moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles, %0d verdicts outstanding",
                  $time, WATCHDOG_LIMIT, expected_verdicts.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_unit_frustum();
      test_matrix_extremes();
      test_random_spheres();
      settle_pipeline();
      // Allow a stray late verdict to surface before judging.
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      $display("Classified %0d spheres over %0d frustum settings (%0d csr beats).",
               spheres_sent, settings_loaded, csr_beats);
      $display("Verdicts checked: %0d inside, %0d intersecting, %0d outside.",
               inside_seen, intersect_seen, outside_seen);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### files.f
rtl/sfc_pkg.sv
rtl/sfc_mul.sv
rtl/sfc_cfg.sv
rtl/sphere_frustum_cull.sv
tb/sv/tb_top.sv
